### src/qte_pkg.sv
package qte_pkg;

  // one quaternion, signed q1.14 components
  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  // one set of euler angles, 32768 stands for pi
  typedef struct packed {
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic               pitch_clamped;
  } euler_t;

  // cordic operand width, holds 2^33 times the cordic gain with margin
  localparam int unsigned OPW = 37;
  // width of the square root remainder and result registers
  localparam int unsigned SQW = 58;
  // result bits of the square root of a value up to 2^56
  localparam int unsigned SQ_STEPS = 29;
  // width of the clamped sine of pitch, +/- 2^28
  localparam int unsigned SW = 30;
  localparam int unsigned ATAN_LEN = 24;

  localparam logic signed [OPW-1:0] ONE_Q28 = OPW'(64'sd1 <<< 28);
  localparam logic signed [OPW-1:0] MINUS_ONE_Q28 = -ONE_Q28;
  localparam logic [SQW-1:0] ONE_SQ = SQW'(64'd1 << 56);

  localparam logic [31:0] ANG_QUARTER = 32'h4000_0000;
  localparam logic [31:0] ANG_MQUARTER = 32'hC000_0000;
  localparam logic [31:0] ANG_HALF_LSB = 32'h0000_8000;

  localparam logic signed [15:0] PITCH_MAX = 16'sd16384;
  localparam logic signed [15:0] PITCH_MIN = -16'sd16384;

  // atan(2^-i) as a 32-bit binary angle, 2^31 is pi
  function automatic logic [31:0] atan_unit(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:       r = 32'd536870912;
      1:       r = 32'd316933406;
      2:       r = 32'd167458907;
      3:       r = 32'd85004756;
      4:       r = 32'd42667331;
      5:       r = 32'd21354465;
      6:       r = 32'd10679838;
      7:       r = 32'd5340245;
      8:       r = 32'd2670163;
      9:       r = 32'd1335087;
      10:      r = 32'd667544;
      11:      r = 32'd333772;
      12:      r = 32'd166886;
      13:      r = 32'd83443;
      14:      r = 32'd41722;
      15:      r = 32'd20861;
      16:      r = 32'd10430;
      17:      r = 32'd5215;
      18:      r = 32'd2608;
      19:      r = 32'd1304;
      20:      r = 32'd652;
      21:      r = 32'd326;
      22:      r = 32'd163;
      23:      r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

### src/qte_cordic.sv
module qte_cordic import qte_pkg::*; #(
  parameter int unsigned NUM_STEPS = 16
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic signed [OPW-1:0] x_i,
  input  logic signed [OPW-1:0] y_i,
  output logic signed [15:0]    angle_o
);

  logic signed [OPW-1:0] x_q   [NUM_STEPS+1];
  logic signed [OPW-1:0] y_q   [NUM_STEPS+1];
  logic        [31:0]    ang_q [NUM_STEPS+1];
  logic                  zero_q [NUM_STEPS+1];

  logic signed [OPW-1:0] x0_d, y0_d;
  logic        [31:0]    ang0_d;
  logic        [31:0]    ang_fin;
  logic        [31:0]    ang_rnd;

  // quarter turn into the right half plane
  always_comb begin
    x0_d   = x_i;
    y0_d   = y_i;
    ang0_d = '0;
    if (x_i < 0) begin
      if (y_i >= 0) begin
        x0_d   = y_i;
        y0_d   = -x_i;
        ang0_d = ANG_QUARTER;
      end else begin
        x0_d   = -y_i;
        y0_d   = x_i;
        ang0_d = ANG_MQUARTER;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= x0_d;
      y_q[0]    <= y0_d;
      ang_q[0]  <= ang0_d;
      zero_q[0] <= (x_i == '0) && (y_i == '0);
    end
  end

  // one vectoring micro-rotation per stage
  for (genvar i = 0; i < NUM_STEPS; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!y_q[i][OPW-1]) begin
          x_q[i+1]   <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] - (x_q[i] >>> i);
          ang_q[i+1] <= ang_q[i] + atan_unit(i);
        end else begin
          x_q[i+1]   <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1]   <= y_q[i] + (x_q[i] >>> i);
          ang_q[i+1] <= ang_q[i] - atan_unit(i);
        end
        zero_q[i+1] <= zero_q[i];
      end
    end
  end

  // round to a 16-bit binary angle
  assign ang_fin = zero_q[NUM_STEPS] ? '0 : ang_q[NUM_STEPS];
  assign ang_rnd = ang_fin + ANG_HALF_LSB;
  assign angle_o = ang_rnd[31:16];

endmodule

### src/quaternion_to_euler_zyx_unit.sv
// Quaternion to yaw-pitch-roll (Z-Y-X) Euler angles. Takes one signed q1.14
// quaternion per cycle and returns roll, pitch and yaw as 16-bit binary
// angles (32768 is pi) plus a flag set when the sine of pitch was clamped to
// unit magnitude. Throughput is one transfer per cycle. The pipeline holds
// the product and sum stages, the 29-stage square root that forms the cosine
// of pitch, and the CORDIC stage chain shared in length by all three angles.
// Output back-pressure stalls the whole pipeline.
module quaternion_to_euler_zyx_unit import qte_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  quat_t  in_data_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output euler_t out_data_o
);

  localparam int unsigned NSTEP = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int unsigned DEPTH = NSTEP + SQ_STEPS + 5;

  logic en;
  logic [DEPTH-1:0] vld_q;

  logic signed [31:0] p_wx_q, p_yz_q, p_xx_q, p_yy_q, p_zz_q;
  logic signed [31:0] p_wy_q, p_zx_q, p_wz_q, p_xy_q;

  logic signed [OPW-1:0] ry_q, rx_q, yy_q, yx_q, s_q;
  logic                  clamp_q;
  logic signed [OPW-1:0] s_raw;

  logic signed [OPW-1:0] dry_q [SQ_STEPS+1];
  logic signed [OPW-1:0] drx_q [SQ_STEPS+1];
  logic signed [OPW-1:0] dyy_q [SQ_STEPS+1];
  logic signed [OPW-1:0] dyx_q [SQ_STEPS+1];
  logic signed [OPW-1:0] ds_q  [SQ_STEPS+1];
  logic                  dcl_q [SQ_STEPS+1];
  logic [SQW-1:0]        rem_q [SQ_STEPS+1];
  logic [SQW-1:0]        res_q [SQ_STEPS+1];

  logic                  ccl_q [NSTEP+1];

  logic signed [SW-1:0]  s_n;
  logic signed [2*SW-1:0] s_sq;
  logic signed [OPW-1:0] cos_op;
  logic signed [15:0]    roll_a, pitch_a, yaw_a, pitch_sat;
  euler_t                out_q;

  // whole pipeline advances unless the output is held
  assign en         = !vld_q[DEPTH-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[DEPTH-2:0], in_valid_i};
    end
  end

  // component products
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_wx_q <= in_data_i.quat_w * in_data_i.quat_x;
      p_yz_q <= in_data_i.quat_y * in_data_i.quat_z;
      p_xx_q <= in_data_i.quat_x * in_data_i.quat_x;
      p_yy_q <= in_data_i.quat_y * in_data_i.quat_y;
      p_zz_q <= in_data_i.quat_z * in_data_i.quat_z;
      p_wy_q <= in_data_i.quat_w * in_data_i.quat_y;
      p_zx_q <= in_data_i.quat_z * in_data_i.quat_x;
      p_wz_q <= in_data_i.quat_w * in_data_i.quat_z;
      p_xy_q <= in_data_i.quat_x * in_data_i.quat_y;
    end
  end

  // arctangent operands and clamped sine of pitch
  assign s_raw = (OPW'(p_wy_q) - OPW'(p_zx_q)) <<< 1;

  always_ff @(posedge clk_i) begin
    if (en) begin
      ry_q <= (OPW'(p_wx_q) + OPW'(p_yz_q)) <<< 1;
      rx_q <= ONE_Q28 - ((OPW'(p_xx_q) + OPW'(p_yy_q)) <<< 1);
      yy_q <= (OPW'(p_wz_q) + OPW'(p_xy_q)) <<< 1;
      yx_q <= ONE_Q28 - ((OPW'(p_yy_q) + OPW'(p_zz_q)) <<< 1);
      if (s_raw > ONE_Q28) begin
        s_q     <= ONE_Q28;
        clamp_q <= 1'b1;
      end else if (s_raw < MINUS_ONE_Q28) begin
        s_q     <= MINUS_ONE_Q28;
        clamp_q <= 1'b1;
      end else begin
        s_q     <= s_raw;
        clamp_q <= 1'b0;
      end
    end
  end

  // radicand 1 - s*s
  assign s_n  = s_q[SW-1:0];
  assign s_sq = s_n * s_n;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rem_q[0] <= ONE_SQ - SQW'(s_sq);
      res_q[0] <= '0;
      dry_q[0] <= ry_q;
      drx_q[0] <= rx_q;
      dyy_q[0] <= yy_q;
      dyx_q[0] <= yx_q;
      ds_q[0]  <= s_q;
      dcl_q[0] <= clamp_q;
    end
  end

  // restoring square root, one result bit per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (SQ_STEPS - 1 - j));
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (rem_q[j] >= res_q[j] + BIT) begin
          rem_q[j+1] <= rem_q[j] - (res_q[j] + BIT);
          res_q[j+1] <= (res_q[j] >> 1) + BIT;
        end else begin
          rem_q[j+1] <= rem_q[j];
          res_q[j+1] <= res_q[j] >> 1;
        end
        dry_q[j+1] <= dry_q[j];
        drx_q[j+1] <= drx_q[j];
        dyy_q[j+1] <= dyy_q[j];
        dyx_q[j+1] <= dyx_q[j];
        ds_q[j+1]  <= ds_q[j];
        dcl_q[j+1] <= dcl_q[j];
      end
    end
  end

  assign cos_op = OPW'(res_q[SQ_STEPS]);

  // three cordic chains in lockstep
  qte_cordic #(.NUM_STEPS(NSTEP)) u_roll (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (drx_q[SQ_STEPS]),
    .y_i    (dry_q[SQ_STEPS]),
    .angle_o(roll_a)
  );

  qte_cordic #(.NUM_STEPS(NSTEP)) u_pitch (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (cos_op),
    .y_i    (ds_q[SQ_STEPS]),
    .angle_o(pitch_a)
  );

  qte_cordic #(.NUM_STEPS(NSTEP)) u_yaw (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (dyx_q[SQ_STEPS]),
    .y_i    (dyy_q[SQ_STEPS]),
    .angle_o(yaw_a)
  );

  // clamp flag alongside the cordic stages
  always_ff @(posedge clk_i) begin
    if (en) begin
      ccl_q[0] <= dcl_q[SQ_STEPS];
      for (int k = 0; k < NSTEP; k++) begin
        ccl_q[k+1] <= ccl_q[k];
      end
    end
  end

  // pitch limited to +/- pi/2
  always_comb begin
    pitch_sat = pitch_a;
    if (pitch_a > PITCH_MAX) begin
      pitch_sat = PITCH_MAX;
    end else if (pitch_a < PITCH_MIN) begin
      pitch_sat = PITCH_MIN;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.roll_angle    <= roll_a;
      out_q.pitch_angle   <= pitch_sat;
      out_q.yaw_angle     <= yaw_a;
      out_q.pitch_clamped <= ccl_q[NSTEP];
    end
  end

  assign out_valid_o = vld_q[DEPTH-1];
  assign out_data_o  = out_q;

  // pitch stays within a quarter turn
  a_pitch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pitch_angle <= PITCH_MAX &&
                     out_data_o.pitch_angle >= PITCH_MIN))
    else $error("pitch outside quarter turn");

  // a stall freezes every valid bit in the pipeline
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(vld_q))
    else $error("pipeline moved during stall");

endmodule
